// ===== rtl/hivc_pkg.sv =====
// Package for the interrupt vector controller: action and size codes, register map
// constants, controller state type and the command/status structs.
// No dependencies.
package hivc_pkg;

    localparam int ROWS = 32;
    localparam int ROW_AW = 5;

    localparam logic [7:0] STATUS_BASE = 8'd128;
    localparam logic [7:0] ENABLE_BASE = 8'd160;
    localparam logic [7:0] AREA_SPAN = 8'd32;

    localparam logic [1:0] ACT_READ = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_IRQ = 2'd2;

    localparam logic [1:0] SZ_1 = 2'd0;
    localparam logic [1:0] SZ_2 = 2'd1;
    localparam logic [1:0] SZ_4 = 2'd2;
    localparam logic [1:0] SZ_8 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MODIFY,
        S_RD_ST,
        S_RD_EN,
        S_LINE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RSEL_ITEM,
        RSEL_STATUS,
        RSEL_ENABLE
    } t_rsel;

    typedef struct packed {
        logic  accept;
        logic  rd_en;
        t_rsel rd_sel;
        logic  modify;
        logic  cap_st;
        logic  line_upd;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic need_line;
        logic out_free;
    } t_sts;

    function automatic logic [63:0] byte_mask(input logic [1:0] size);
        logic [63:0] m;
        begin
            unique case (size)
                SZ_1: m = 64'h0000_0000_0000_00ff;
                SZ_2: m = 64'h0000_0000_0000_ffff;
                SZ_4: m = 64'h0000_0000_ffff_ffff;
                default: m = 64'hffff_ffff_ffff_ffff;
            endcase
            return m;
        end
    endfunction

    function automatic logic [7:0] align_off(input logic [7:0] off, input logic [1:0] size);
        logic [2:0] low;
        begin
            unique case (size)
                SZ_1: low = off[2:0];
                SZ_2: low = {off[2:1], 1'b0};
                SZ_4: low = {off[2], 2'b00};
                default: low = 3'b000;
            endcase
            return {off[7:3], low};
        end
    endfunction

endpackage

// ===== rtl/ht_interrupt_vector_controller_core.sv =====
// Reads, raw writes and ignored items pass from input accept through fetch, modify and done; an
// item that updates a line also passes status read, enable read and line update after modify.
// A new item is taken only once the previous one has passed the read-modify-write sequence on the
// register memory and been loaded into the output register, which lets the next item in.
// Reset (i_rst_n low, synchronous): register space reads as zero (row valid bits cleared),
// line levels zero, controller idle, no result pending. No clearing pass.
module ht_interrupt_vector_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // action[1:0], reg_offset[9:2], access_size[11:10], write_data[75:12],
    // irq_number[83:76], irq_level[84], zero[87:85]
    input  logic [87:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_data[63:0], line_levels[71:64]
    output logic [71:0] o_m_tdata
);
    import hivc_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [63:0] w_read_data;
    logic [7:0]  w_line_levels;

    hivc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hivc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_action      (i_s_tdata[1:0]),
        .i_reg_offset  (i_s_tdata[9:2]),
        .i_access_size (i_s_tdata[11:10]),
        .i_write_data  (i_s_tdata[75:12]),
        .i_irq_number  (i_s_tdata[83:76]),
        .i_irq_level   (i_s_tdata[84]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_read_data   (w_read_data),
        .o_line_levels (w_line_levels)
    );

    assign o_m_tdata = {w_line_levels, w_read_data};

endmodule

// ===== rtl/hivc_ctrl.sv =====
// Controller state machine of the interrupt vector controller.
// Depends on hivc_pkg; drives hivc_dp through t_cmd, watches t_sts.
module hivc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  hivc_pkg::t_sts i_sts,
    output hivc_pkg::t_cmd o_cmd
);
    import hivc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.rd_sel = RSEL_ITEM;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state = i_sts.need_line ? S_RD_ST : S_DONE;
            end
            S_RD_ST: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = RSEL_STATUS;
                n_state = S_RD_EN;
            end
            S_RD_EN: begin
                o_cmd.cap_st = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = RSEL_ENABLE;
                n_state = S_LINE;
            end
            S_LINE: begin
                o_cmd.line_upd = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/hivc_dp.sv =====
// Datapath of the interrupt vector controller: item latch, 32x64 register memory
// with per-row valid bits, byte merge, line levels and output register. Uses hivc_pkg.
module hivc_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hivc_pkg::t_cmd i_cmd,
    output hivc_pkg::t_sts o_sts,
    input  logic [1:0]     i_action,
    input  logic [7:0]     i_reg_offset,
    input  logic [1:0]     i_access_size,
    input  logic [63:0]    i_write_data,
    input  logic [7:0]     i_irq_number,
    input  logic           i_irq_level,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output logic [63:0]    o_read_data,
    output logic [7:0]     o_line_levels
);
    import hivc_pkg::*;

    logic [63:0] r_mem [ROWS];
    logic [ROWS-1:0] r_row_vld;
    logic [63:0] r_rd_data;
    logic r_rd_vld;

    logic [1:0]  r_act;
    logic [7:0]  r_off;
    logic [1:0]  r_size;
    logic [63:0] r_wdata;
    logic [7:0]  r_irq;
    logic        r_lvl;

    logic [63:0] r_res;
    logic [31:0] r_st_word;
    logic [7:0]  r_levels;
    logic        r_out_vld;
    logic [63:0] r_out_data;
    logic [7:0]  r_out_lvl;

    logic [7:0]  w_irq_off;
    logic [7:0]  w_tgt_off;
    logic [7:0]  w_st_d;
    logic [7:0]  w_en_d;
    logic        w_st_hit;
    logic        w_en_hit;
    logic [2:0]  w_k;
    logic [7:0]  w_lst_off;
    logic [7:0]  w_len_off;
    logic [ROW_AW-1:0] w_rd_addr;
    logic [63:0] w_row;
    logic [5:0]  w_sh;
    logic [31:0] w_cur;
    logic [31:0] w_bit;
    logic        w_wr_en;
    logic [63:0] w_wval;
    logic [1:0]  w_wsize;
    logic        w_need_line;
    logic [63:0] w_bm;
    logic [63:0] w_new_row;
    logic [63:0] w_rd_res;
    logic [31:0] w_en_word;

    assign w_irq_off = STATUS_BASE + {3'b000, r_irq[7:5], 2'b00};
    assign w_tgt_off = (r_act == ACT_IRQ) ? w_irq_off : r_off;
    assign w_st_d = r_off - STATUS_BASE;
    assign w_en_d = r_off - ENABLE_BASE;
    assign w_st_hit = (r_off >= STATUS_BASE) && (w_st_d < AREA_SPAN) && (w_st_d[1:0] == 2'b00);
    assign w_en_hit = (r_off >= ENABLE_BASE) && (w_en_d < AREA_SPAN) && (w_en_d[1:0] == 2'b00);

    always_comb begin
        if (r_act == ACT_IRQ) begin
            w_k = r_irq[7:5];
        end else if (w_st_hit) begin
            w_k = w_st_d[4:2];
        end else begin
            w_k = w_en_d[4:2];
        end
    end

    assign w_lst_off = STATUS_BASE + {3'b000, w_k, 2'b00};
    assign w_len_off = ENABLE_BASE + {3'b000, w_k, 2'b00};

    always_comb begin
        unique case (i_cmd.rd_sel)
            RSEL_STATUS: w_rd_addr = w_lst_off[7:3];
            RSEL_ENABLE: w_rd_addr = w_len_off[7:3];
            default:     w_rd_addr = w_tgt_off[7:3];
        endcase
    end

    assign w_row = r_rd_vld ? r_rd_data : 64'd0;
    assign w_sh = {w_tgt_off[2:0], 3'b000};
    assign w_cur = 32'(w_row >> w_sh);
    assign w_bit = 32'd1 << r_irq[4:0];

    always_comb begin
        w_wr_en = 1'b0;
        w_wval = r_wdata;
        w_wsize = r_size;
        w_need_line = 1'b0;
        case (r_act)
            ACT_WRITE: begin
                if (w_st_hit) begin
                    if (r_size == SZ_4) begin
                        w_wr_en = 1'b1;
                        w_wval = {32'd0, w_cur & ~r_wdata[31:0]};
                        w_need_line = 1'b1;
                    end
                end else if (w_en_hit) begin
                    if (r_size == SZ_4) begin
                        w_wr_en = 1'b1;
                        w_wval = {32'd0, r_wdata[31:0]};
                        w_need_line = 1'b1;
                    end
                end else begin
                    w_wr_en = 1'b1;
                end
            end
            ACT_IRQ: begin
                w_wr_en = 1'b1;
                w_wsize = SZ_4;
                w_wval = {32'd0, r_lvl ? (w_cur | w_bit) : (w_cur & ~w_bit)};
                w_need_line = 1'b1;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    assign w_bm = byte_mask(w_wsize);
    assign w_new_row = (w_row & ~(w_bm << w_sh)) | ((w_wval & w_bm) << w_sh);
    assign w_rd_res = (r_act == ACT_READ) ? ((w_row >> w_sh) & byte_mask(r_size)) : 64'd0;
    assign w_en_word = 32'(w_row >> {w_len_off[2:0], 3'b000});

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (i_cmd.modify && w_wr_en) begin
            r_mem[w_tgt_off[7:3]] <= w_new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld <= 1'b0;
            r_levels <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_row_vld[w_rd_addr];
            end
            if (i_cmd.modify && w_wr_en) begin
                r_row_vld[w_tgt_off[7:3]] <= 1'b1;
            end
            if (i_cmd.line_upd) begin
                r_levels[w_k] <= |(r_st_word & w_en_word);
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act <= i_action;
            r_off <= align_off(i_reg_offset, i_access_size);
            r_size <= i_access_size;
            r_wdata <= i_write_data;
            r_irq <= i_irq_number;
            r_lvl <= i_irq_level;
        end
        if (i_cmd.modify) begin
            r_res <= w_rd_res;
        end
        if (i_cmd.cap_st) begin
            r_st_word <= 32'(w_row >> {w_lst_off[2:0], 3'b000});
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
            r_out_lvl <= r_levels;
        end
    end

    assign o_sts.need_line = w_need_line;
    assign o_sts.out_free = !r_out_vld || i_m_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_read_data = r_out_data;
    assign o_line_levels = r_out_lvl;

endmodule

// ===== rtl/hivc_checker.sv =====
// Port-level checker for the interrupt vector controller core, bound to the top level.
// Depends only on the core's ports.
module hivc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item taken while previous item in work");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared one cycle after accept");

endmodule

bind ht_interrupt_vector_controller_core hivc_checker u_hivc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
